>>> rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths, item types and constants of the 3-D vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

  // component width; results are signed Q1.(CB-1)
  localparam int CB       = 16;
  // sum of three squares of magnitudes fits in 2*CB bits
  localparam int SW       = 2 * CB;
  // running remainder of the root search, signed
  localparam int DW       = 4 * CB + 4;
  // running product (2q-1)*s, signed
  localparam int QW       = 3 * CB + 2;
  // register stages of one quotient lane: init stage plus one stage per bit
  localparam int LANE_LAT = CB + 1;

  localparam logic [CB-1:0] MAXPOS = {1'b0, {(CB-1){1'b1}}};

  typedef struct packed {
    logic signed [CB-1:0] x_in;
    logic signed [CB-1:0] y_in;
    logic signed [CB-1:0] z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [CB-1:0] x_out;
    logic signed [CB-1:0] y_out;
    logic signed [CB-1:0] z_out;
    logic                 was_zero;
  } out_item_t;

  // control that travels beside the quotient lanes
  typedef struct packed {
    logic       vld;
    logic [2:0] neg;
    logic       zero;
  } side_t;

endpackage

>>> rtl/vn_lane.sv
// ----------------------------------------------------------------------------
// vn_lane
// One component's quotient: round(c * 2^(CB-1) / sqrt(s)), found one bit
// per pipeline stage with an add-and-compare on running terms.
// ----------------------------------------------------------------------------
module vn_lane import vn_pkg::*; (
  input  logic          clk,
  input  logic [SW-1:0] s,
  input  logic [SW-1:0] c2,
  output logic [CB-1:0] q
);

  // per stage: remainder c2*2^(2CB) - (2q-1)^2*s, product (2q-1)*s, s, q
  logic signed [DW-1:0] d_r  [0:CB];
  logic signed [QW-1:0] p_r  [0:CB];
  logic        [SW-1:0] s_r  [0:CB];
  logic        [CB-1:0] q_r  [0:CB];

  // load the search with q = 0, that is 2q-1 = -1
  always_ff @(posedge clk) begin
    d_r[0] <= signed'(DW'(c2) << SW) - signed'(DW'(s));
    p_r[0] <= -signed'(QW'(s));
    s_r[0] <= s;
    q_r[0] <= '0;
  end

  // try one bit of q per stage, most significant first
  for (genvar g = 0; g < CB; g++) begin : g_step
    localparam int K = CB - 1 - g;
    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] trial;
    logic                 ok;

    assign sx    = signed'(DW'(s_r[g]));
    assign trial = d_r[g] - (DW'(p_r[g]) <<< (K + 2)) - (sx <<< (2 * K + 2));
    assign ok    = !trial[DW-1];

    always_ff @(posedge clk) begin
      s_r[g+1] <= s_r[g];
      if (ok) begin
        d_r[g+1] <= trial;
        p_r[g+1] <= p_r[g] + (signed'(QW'(s_r[g])) <<< (K + 1));
        q_r[g+1] <= q_r[g] | (CB'(1) << K);
      end else begin
        d_r[g+1] <= d_r[g];
        p_r[g+1] <= p_r[g];
        q_r[g+1] <= q_r[g];
      end
    end
  end

  assign q = q_r[CB];

endmodule

>>> rtl/vec3_normalize.sv
// ----------------------------------------------------------------------------
// vec3_normalize
// Scales a signed integer 3-D vector to unit length in signed Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and raise start; the item is taken at any edge where
//   start is high, since busy is always low: one item per cycle.
//   Each result appears on out_data for exactly one cycle with out_valid
//   high, in input order. Pipeline: magnitude register, squaring register,
//   search load, 16 root search stages (one quotient bit each, three lanes
//   side by side) and the output register, 20 registers in all.
//   Throughput is one item per clock.
//   Each component is rounded to nearest, ties away from zero; +1.0
//   saturates to 32767, -1.0 stays -32768. The zero vector gives
//   (32767, 0, 0) with was_zero set.
//   Reset clears all valid bits; items in flight are dropped. The receiver
//   cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module vec3_normalize import vn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  logic          va_r;
  logic [CB-1:0] mag_r [0:2];
  logic [2:0]    nega_r;
  logic          vb_r;
  logic [SW-1:0] sq_r  [0:2];
  logic [2:0]    negb_r;
  logic [SW-1:0] s_sum;
  logic [CB-1:0] q     [0:2];
  side_t         side_r [0:LANE_LAT-1];
  side_t         side_end;
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic signed [CB-1:0] in_c [0:2];

  assign busy = 1'b0;
  assign in_c[0] = in_data.x_in;
  assign in_c[1] = in_data.y_in;
  assign in_c[2] = in_data.z_in;

  // track valid, take magnitudes and signs, then square the magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= start && !busy;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nega_r[i] <= in_c[i][CB-1];
      mag_r[i]  <= in_c[i][CB-1] ? (~in_c[i] + CB'(1)) : in_c[i];
      sq_r[i]   <= SW'(mag_r[i]) * SW'(mag_r[i]);
    end
    negb_r <= nega_r;
  end

  // sum of squares feeds all three lanes
  assign s_sum = sq_r[0] + sq_r[1] + sq_r[2];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vn_lane u_lane (
      .clk (clk),
      .s   (s_sum),
      .c2  (sq_r[i]),
      .q   (q[i])
    );
  end

  // carry valid, signs and zero flag beside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) side_r[i] <= '0;
    end else begin
      side_r[0] <= '{vld: vb_r, neg: negb_r, zero: (s_sum == '0)};
      for (int i = 1; i < LANE_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign side_end = side_r[LANE_LAT-1];

  // encode signs, saturate +1.0, substitute the zero-vector result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (side_end.zero) begin
      out_data_r <= '{x_out: MAXPOS, y_out: '0, z_out: '0, was_zero: 1'b1};
    end else begin
      out_data_r.x_out <= side_end.neg[0] ? (~q[0] + CB'(1)) :
                          ((q[0] > MAXPOS) ? MAXPOS : q[0]);
      out_data_r.y_out <= side_end.neg[1] ? (~q[1] + CB'(1)) :
                          ((q[1] > MAXPOS) ? MAXPOS : q[1]);
      out_data_r.z_out <= side_end.neg[2] ? (~q[2] + CB'(1)) :
                          ((q[2] > MAXPOS) ? MAXPOS : q[2]);
      out_data_r.was_zero <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // zero vector always leaves as (max, 0, 0)
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_zero |->
      out_data.x_out == MAXPOS && out_data.y_out == '0 && out_data.z_out == '0)
    else $error("zero vector result malformed");

  // a lane quotient never exceeds 1.0 unless the zero vector overrides it
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    side_end.vld && !side_end.zero |->
      q[0] <= (MAXPOS + CB'(1)) && q[1] <= (MAXPOS + CB'(1)) &&
      q[2] <= (MAXPOS + CB'(1)))
    else $error("quotient above one");

  // each result follows a valid entry at the lane output
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(side_end.vld))
    else $error("result without item");

endmodule
